// File: src/can_id_tracking_table_assert.svh
// assertion macros for the can identifier tracking table
// used by the port checker; no other dependencies
`ifndef CAN_ID_TRACKING_TABLE_ASSERT_SVH
`define CAN_ID_TRACKING_TABLE_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define CITT_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define CITT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/citt_pkg.sv
// shared types and constants for the can identifier tracking table
// no dependencies; imported by the interfaces and every module
package citt_pkg;

   // payload field widths
   localparam int FRAME_ID_W  = 29;
   localparam int FRAME_LEN_W = 4;
   localparam int PAYLOAD_W   = 64;
   localparam int TIME_W      = 32;
   localparam int ENTRY_IDX_W = 7;
   localparam int COUNT_W     = 8;

   // most identifiers the table will ever learn
   localparam int ENTRY_LIMIT = 100;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] REG_FOCUS_MODE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FOCUSED_ENTRY = 1'd1;

   // datapath actions that close one frame
   typedef logic [2:0] act_type;
   localparam act_type ACT_NONE = 3'd0;  // nothing this cycle
   localparam act_type ACT_MISS = 3'd1;  // result without any write
   localparam act_type ACT_HIT  = 3'd2;  // refresh an existing entry
   localparam act_type ACT_NEW  = 3'd3;  // append a new entry
   localparam act_type ACT_FULL = 3'd4;  // unknown identifier dropped

   typedef struct packed {
      logic                   focus_mode;
      logic [ENTRY_IDX_W-1:0] focused_entry;
   } cfg_type;

   typedef struct packed {
      logic    frame_load;
      logic    scan_clr;
      logic    rd_en;
      logic    rd_focus;
      act_type act;
   } cmd_type;

   typedef struct packed {
      logic used_zero;
      logic used_full;
      logic scan_done;
      logic focus_ok;
      logic id_match;
   } status_type;

   typedef struct packed {
      logic [ENTRY_IDX_W-1:0] entry_index;
      logic                   was_new;
      logic                   was_updated;
      logic                   table_full;
      logic [TIME_W-1:0]      interval_ms;
      logic [COUNT_W-1:0]     entry_count;
   } result_type;

endpackage

// File: src/citt_req_if.sv
// frame channel carrying one received can frame per beat
// depends on citt_pkg for field widths
interface citt_req_if
   import citt_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [FRAME_ID_W-1:0]  frame_id;
   logic [FRAME_LEN_W-1:0] frame_length;
   logic [PAYLOAD_W-1:0]   frame_payload;
   logic [TIME_W-1:0]      now_ms;

   modport source (output valid, frame_id, frame_length, frame_payload, now_ms,
                   input ready);
   modport sink (input valid, frame_id, frame_length, frame_payload, now_ms,
                 output ready);
endinterface

// File: src/citt_rsp_if.sv
// result channel carrying one lookup outcome per beat
// depends on citt_pkg for field widths
interface citt_rsp_if
   import citt_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [ENTRY_IDX_W-1:0] entry_index;
   logic                   was_new;
   logic                   was_updated;
   logic                   table_full;
   logic [TIME_W-1:0]      interval_ms;
   logic [COUNT_W-1:0]     entry_count;

   modport source (output valid, entry_index, was_new, was_updated, table_full,
                   interval_ms, entry_count, input ready);
   modport sink (input valid, entry_index, was_new, was_updated, table_full,
                 interval_ms, entry_count, output ready);
endinterface

// File: src/citt_csr_if.sv
// configuration write channel: register index and write data per beat
// depends on citt_pkg for field widths
interface citt_csr_if
   import citt_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: src/citt_csr.sv
// configuration registers: focus mode and focused entry
// depends on citt_pkg and citt_csr_if
module citt_csr
   import citt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   citt_csr_if.sink    csr_bus,
   output cfg_type     cfg
);
   logic                   focus_mode_ff;
   logic                   focus_mode_in;
   logic [ENTRY_IDX_W-1:0] focused_entry_ff;
   logic [ENTRY_IDX_W-1:0] focused_entry_in;

   // writes are always taken
   assign csr_bus.ready = 1'b1;

   // register decode
   always_comb begin
      focus_mode_in    = focus_mode_ff;
      focused_entry_in = focused_entry_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_FOCUS_MODE:    focus_mode_in    = csr_bus.data[0];
            REG_FOCUSED_ENTRY: focused_entry_in = csr_bus.data[ENTRY_IDX_W-1:0];
            default:           focus_mode_in    = focus_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         focus_mode_ff    <= 1'b0;
         focused_entry_ff <= '0;
      end else begin
         focus_mode_ff    <= focus_mode_in;
         focused_entry_ff <= focused_entry_in;
      end
   end

   assign cfg.focus_mode    = focus_mode_ff;
   assign cfg.focused_entry = focused_entry_ff;
endmodule

// File: src/citt_ctrl.sv
// sequencer for one frame: accept, search or focus check, result beat
// depends on citt_pkg for command and status types
module citt_ctrl
   import citt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       focus_mode,
   input  status_type status,
   output cmd_type    cmd
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_FCHK  = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       cmp_vld_ff;   // a read is waiting to be compared
   logic       cmp_vld_in;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cmp_vld_in     = 1'b0;
      cmd.frame_load = 1'b0;
      cmd.scan_clr   = 1'b0;
      cmd.rd_en      = 1'b0;
      cmd.rd_focus   = 1'b0;
      cmd.act        = ACT_NONE;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.frame_load = 1'b1;
               cmd.scan_clr   = 1'b1;
               state_in       = S_START;
            end
         end
         S_START: begin
            // an empty table always takes the frame as entry 0
            if (status.used_zero) begin
               cmd.act  = ACT_NEW;
               state_in = S_OUT;
            end else if (focus_mode) begin
               if (status.focus_ok) begin
                  cmd.rd_en    = 1'b1;
                  cmd.rd_focus = 1'b1;
                  state_in     = S_FCHK;
               end else begin
                  cmd.act  = ACT_MISS;
                  state_in = S_OUT;
               end
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // one read issued per cycle, each compared once its registered data is back
            if (cmp_vld_ff && status.id_match) begin
               cmd.act  = ACT_HIT;
               state_in = S_OUT;
            end else if (status.scan_done) begin
               cmd.act  = status.used_full ? ACT_FULL : ACT_NEW;
               state_in = S_OUT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmp_vld_in = 1'b1;
            end
         end
         S_FCHK: begin
            cmd.act  = status.id_match ? ACT_HIT : ACT_MISS;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end
endmodule

// File: src/citt_dp.sv
// datapath: identifier and last-seen memories, scan counter, result register
// depends on citt_pkg for command, status and result types
module citt_dp
   import citt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic [ENTRY_IDX_W-1:0] focused_entry,
   input  logic [FRAME_ID_W-1:0]  frame_id,
   input  logic [TIME_W-1:0]      now_ms,
   output status_type             status,
   output result_type             result
);
   localparam int CAPACITY = (ENTRY_LIMIT < TABLE_ENTRIES) ? ENTRY_LIMIT : TABLE_ENTRIES;
   localparam int IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   logic [FRAME_ID_W-1:0] id_mem   [TABLE_ENTRIES];
   logic [TIME_W-1:0]     seen_mem [TABLE_ENTRIES];

   logic [FRAME_ID_W-1:0] frame_id_ff;
   logic [TIME_W-1:0]     now_ff;
   logic [FRAME_ID_W-1:0] id_rd_ff;
   logic [TIME_W-1:0]     seen_rd_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic [CNT_W-1:0]      scan_ff;
   logic [CNT_W-1:0]      scan_in;
   logic [CNT_W-1:0]      used_ff;
   logic [CNT_W-1:0]      used_in;
   result_type            result_ff;
   result_type            result_in;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      wr_addr;
   logic                  wr_en;

   // frame held for the whole search
   always_ff @(posedge clock) begin
      if (cmd.frame_load) begin
         frame_id_ff <= frame_id;
         now_ff      <= now_ms;
      end
   end

   // read address: scan position or the focused entry
   assign rd_addr = cmd.rd_focus ? IDX_W'(focused_entry) : IDX_W'(scan_ff);

   // write address: entry just hit, or the next free one
   assign wr_en   = (cmd.act == ACT_HIT) || (cmd.act == ACT_NEW);
   assign wr_addr = (cmd.act == ACT_HIT) ? rd_idx_ff : IDX_W'(used_ff);

   // table memories with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem[wr_addr]   <= frame_id_ff;
         seen_mem[wr_addr] <= now_ff;
      end
      if (cmd.rd_en) begin
         id_rd_ff   <= id_mem[rd_addr];
         seen_rd_ff <= seen_mem[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   // scan counter and fill count
   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_clr) begin
         scan_in = '0;
      end else if (cmd.rd_en && !cmd.rd_focus) begin
         scan_in = scan_ff + CNT_W'(1);
      end
      used_in = used_ff;
      if (cmd.act == ACT_NEW) begin
         used_in = used_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         used_ff <= '0;
      end else begin
         scan_ff <= scan_in;
         used_ff <= used_in;
      end
   end

   // result of the closing action
   always_comb begin
      result_in             = result_ff;
      result_in.entry_index = '0;
      result_in.was_new     = 1'b0;
      result_in.was_updated = 1'b0;
      result_in.table_full  = 1'b0;
      result_in.interval_ms = '0;
      result_in.entry_count = COUNT_W'(used_ff);
      case (cmd.act)
         ACT_NONE: result_in = result_ff;
         ACT_MISS: result_in.table_full = 1'b0;
         ACT_FULL: result_in.table_full = 1'b1;
         ACT_HIT: begin
            result_in.entry_index = ENTRY_IDX_W'(rd_idx_ff);
            result_in.was_updated = 1'b1;
            result_in.interval_ms = now_ff - seen_rd_ff;
         end
         ACT_NEW: begin
            result_in.entry_index = ENTRY_IDX_W'(used_ff);
            result_in.was_new     = 1'b1;
            result_in.was_updated = 1'b1;
            result_in.entry_count = COUNT_W'(used_ff) + COUNT_W'(1);
         end
         default: result_in = result_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

   // status back to the sequencer
   assign status.used_zero = (used_ff == '0);
   assign status.used_full = (used_ff == CNT_W'(CAPACITY));
   assign status.scan_done = (scan_ff == used_ff);
   assign status.focus_ok  = (COUNT_W'(focused_entry) < COUNT_W'(used_ff));
   assign status.id_match  = (id_rd_ff == frame_id_ff);
endmodule

// File: src/can_id_tracking_table.sv
// can identifier tracking table, top level
// depends on citt_pkg, the three channel interfaces, citt_csr, citt_ctrl, citt_dp
//
// req_bus takes one received frame per beat (identifier, length, payload,
// millisecond tick); rsp_bus returns exactly one result beat per frame;
// csr_bus writes focus_mode (index 0) and focused_entry (index 1), always ready.
// One frame is handled at a time: req_bus.ready is high only while idle.
// Path from frame beat to result beat, from IDLE through START to OUT:
//   empty table or focus miss on an unfilled entry: START goes straight to OUT
//   focus mode with a filled focused entry: START reads it, FCHK compares it
//   table mode: SCAN reads the identifier memory one entry per cycle from
//   entry 0 until a hit or until every filled entry is read
// The next frame is taken only once the result beat is accepted and the
// sequencer is back in IDLE, so no frame is taken while one is in work.
// A stalled receiver holds the result beat and the block takes no frame.
// Reset clears the fill and scan counts, the sequencer and the configuration
// registers; memory contents are never cleared, since only entries below the fill count are read.
module can_id_tracking_table
   import citt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 128
) (
   input  logic         clock,
   input  logic         reset,
   citt_req_if.sink     req_bus,
   citt_rsp_if.source   rsp_bus,
   citt_csr_if.sink     csr_bus
);
   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   result_type result;
   logic       req_ready;
   logic       rsp_valid;

   // configuration registers
   citt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // sequencer
   citt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_bus.ready),
      .focus_mode (cfg.focus_mode),
      .status     (status),
      .cmd        (cmd)
   );

   // table datapath
   citt_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .focused_entry (cfg.focused_entry),
      .frame_id      (req_bus.frame_id),
      .now_ms        (req_bus.now_ms),
      .status        (status),
      .result        (result)
   );

   // channel outputs
   assign req_bus.ready       = req_ready;
   assign rsp_bus.valid       = rsp_valid;
   assign rsp_bus.entry_index = result.entry_index;
   assign rsp_bus.was_new     = result.was_new;
   assign rsp_bus.was_updated = result.was_updated;
   assign rsp_bus.table_full  = result.table_full;
   assign rsp_bus.interval_ms = result.interval_ms;
   assign rsp_bus.entry_count = result.entry_count;
endmodule

// File: src/citt_checker.sv
// port checker for the can identifier tracking table, bound to the top level
// depends on citt_pkg and can_id_tracking_table_assert.svh
`include "can_id_tracking_table_assert.svh"

module citt_checker
   import citt_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [ENTRY_IDX_W-1:0] rsp_entry_index,
   input logic                   rsp_was_new,
   input logic                   rsp_was_updated,
   input logic                   rsp_table_full,
   input logic [TIME_W-1:0]      rsp_interval_ms
);
   // a result beat waits until taken
   `CITT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result beat dropped while stalled")

   // no new frame is taken while a result is pending
   `CITT_ASSERT_HOLDS(a_no_overlap, clock, reset, rsp_valid, !req_ready, "frame accepted while result pending")

   // a new entry is always written, with no interval and no full flag
   `CITT_ASSERT_HOLDS(a_new_entry, clock, reset, rsp_valid && rsp_was_new, rsp_was_updated && !rsp_table_full && (rsp_interval_ms == '0), "inconsistent new entry result")

   // without a write the index and interval read as zero
   `CITT_ASSERT_HOLDS(a_no_write, clock, reset, rsp_valid && !rsp_was_updated, (rsp_entry_index == '0) && (rsp_interval_ms == '0), "non-zero fields without a write")
endmodule

bind can_id_tracking_table citt_checker u_citt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_entry_index (rsp_bus.entry_index),
   .rsp_was_new     (rsp_bus.was_new),
   .rsp_was_updated (rsp_bus.was_updated),
   .rsp_table_full  (rsp_bus.table_full),
   .rsp_interval_ms (rsp_bus.interval_ms)
);

// File: tb/citt_tracking_checker.sv
// result checker for the can identifier tracking table: watches the three channels,
// keeps its own copy of the table and compares every result beat field by field
// depends on citt_pkg and the req, rsp and csr channel interfaces
module citt_tracking_checker
   import citt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   citt_req_if  req_bus,
   citt_rsp_if  rsp_bus,
   citt_csr_if  csr_bus,
   output int   fail_count,
   output int   outstanding,
   output int   new_seen,
   output int   refresh_seen,
   output int   dropped_seen
);
   localparam int TABLE_ENTRIES  = 128;
   localparam int TABLE_CAPACITY = (ENTRY_LIMIT < TABLE_ENTRIES) ? ENTRY_LIMIT : TABLE_ENTRIES;

   // length and payload are neither stored nor reported by the block, so only the
   // identifier and the last-seen tick of each entry shape the results
   logic [FRAME_ID_W-1:0] id_mem        [TABLE_ENTRIES];
   logic [TIME_W-1:0]     last_seen_mem [TABLE_ENTRIES];
   int                    fill;
   cfg_type               cfg;
   result_type            expected_results [$];
   result_type            want;
   int                    mismatches;

   // new tick into entry k, returning the time since it was last seen
   function automatic logic [TIME_W-1:0] refresh_entry(input int k,
                                                       input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] elapsed;
      elapsed = now - last_seen_mem[k];
      last_seen_mem[k] = now;
      return elapsed;
   endfunction

   // look one frame up, update the table copy and return the result it should give
   function automatic result_type track_frame(input logic [FRAME_ID_W-1:0] id,
                                              input logic [TIME_W-1:0] now);
      result_type r;
      int         hit_at;
      int         k;
      r = '0;
      // an empty table always takes the first frame as entry 0, in either mode
      if (fill == 0) begin
         id_mem[0] = id;
         last_seen_mem[0] = now;
         fill = 1;
         r.was_new = 1'b1;
         r.was_updated = 1'b1;
      end
      if (!cfg.focus_mode) begin
         hit_at = -1;
         for (k = 0; k < fill; k++) begin
            if (hit_at < 0 && id_mem[k] == id) hit_at = k;
         end
         if (hit_at >= 0) begin
            r.interval_ms = refresh_entry(hit_at, now);
            r.entry_index = hit_at[ENTRY_IDX_W-1:0];
            r.was_updated = 1'b1;
         end else if (fill < TABLE_CAPACITY) begin
            id_mem[fill] = id;
            last_seen_mem[fill] = now;
            r.entry_index = fill[ENTRY_IDX_W-1:0];
            r.interval_ms = '0;
            r.was_new = 1'b1;
            r.was_updated = 1'b1;
            fill++;
         end else begin
            r.table_full = 1'b1;
         end
      end else if (int'(cfg.focused_entry) < fill && id_mem[cfg.focused_entry] == id) begin
         // focus mode: only the focused entry, once filled, can be refreshed
         r.interval_ms = refresh_entry(int'(cfg.focused_entry), now);
         r.entry_index = cfg.focused_entry;
         r.was_updated = 1'b1;
      end
      r.entry_count = fill[COUNT_W-1:0];
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] exp_val,
                                       input logic [63:0] act_val);
      if (act_val !== exp_val) begin
         mismatches++;
         $display("%0t: %s expected %0h, got %0h", $time, name, exp_val, act_val);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fill = 0;
         cfg = '0;
         mismatches = 0;
         expected_results.delete();
         new_seen <= 0;
         refresh_seen <= 0;
         dropped_seen <= 0;
      end else begin
         // configuration beat
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               REG_FOCUS_MODE:    cfg.focus_mode = csr_bus.data[0];
               REG_FOCUSED_ENTRY: cfg.focused_entry = csr_bus.data[ENTRY_IDX_W-1:0];
               default: ;
            endcase
         end
         // result beat against the oldest expectation
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with nothing expected, entry %0h interval %0h",
                        $time, rsp_bus.entry_index, rsp_bus.interval_ms);
            end else begin
               want = expected_results.pop_front();
               check_field("entry_index", want.entry_index, rsp_bus.entry_index);
               check_field("was_new", want.was_new, rsp_bus.was_new);
               check_field("was_updated", want.was_updated, rsp_bus.was_updated);
               check_field("table_full", want.table_full, rsp_bus.table_full);
               check_field("interval_ms", want.interval_ms, rsp_bus.interval_ms);
               check_field("entry_count", want.entry_count, rsp_bus.entry_count);
               new_seen <= new_seen + int'(want.was_new);
               refresh_seen <= refresh_seen + int'(want.was_updated && !want.was_new);
               dropped_seen <= dropped_seen + int'(want.table_full);
            end
         end
         // frame beat: work out what it should return
         if (req_bus.valid && req_bus.ready)
            expected_results.push_back(track_frame(req_bus.frame_id, req_bus.now_ms));
      end
      fail_count <= mismatches;
      outstanding <= expected_results.size();
   end

endmodule

// File: tb/tb_can_id_tracking_table.sv
// testbench top for the can identifier tracking table: clock, reset, frame and
// configuration stimulus, result back-pressure and the final verdict
// depends on citt_pkg, the channel interfaces, the rtl top and citt_tracking_checker
module tb_can_id_tracking_table
   import citt_pkg::*;
();

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 8;

   logic                  clock = 1'b0;
   logic                  reset;
   int                    cycles = 0;
   int                    send_idle_pct = 0;
   int                    recv_stall_pct = 0;
   logic                  focus_on = 1'b0;
   int                    focus_target = 0;
   logic [FRAME_ID_W-1:0] known_ids [$];
   logic [TIME_W-1:0]     tick = '0;
   int                    frames_sent = 0;
   int                    fail_count;
   int                    outstanding;
   int                    new_seen;
   int                    refresh_seen;
   int                    dropped_seen;

   citt_req_if req_bus ();
   citt_rsp_if rsp_bus ();
   citt_csr_if csr_bus ();

   can_id_tracking_table i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   citt_tracking_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_bus      (csr_bus),
      .fail_count   (fail_count),
      .outstanding  (outstanding),
      .new_seen     (new_seen),
      .refresh_seen (refresh_seen),
      .dropped_seen (dropped_seen)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles", $time, cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result back-pressure
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // one frame beat, after a random idle stretch
   task automatic send_frame(input logic [FRAME_ID_W-1:0]  id,
                             input logic [FRAME_LEN_W-1:0] len,
                             input logic [PAYLOAD_W-1:0]   payload,
                             input logic [TIME_W-1:0]      now);
      bit seen;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.frame_id      <= id;
      req_bus.frame_length  <= len;
      req_bus.frame_payload <= payload;
      req_bus.now_ms        <= now;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      frames_sent++;
      // keep the identifiers in entry order so focus rounds can aim at real entries
      seen = 1'b0;
      foreach (known_ids[k]) if (known_ids[k] == id) seen = 1'b1;
      if (!seen && known_ids.size() < ENTRY_LIMIT && (!focus_on || known_ids.size() == 0))
         known_ids.push_back(id);
   endtask

   // random frame: the focused identifier, a known one or a fresh one
   task automatic send_random(input int fresh_pct);
      logic [FRAME_ID_W-1:0]  id;
      logic [FRAME_LEN_W-1:0] len;
      if (focus_on && focus_target < known_ids.size() && $urandom_range(99) < 60)
         id = known_ids[focus_target];
      else if (known_ids.size() == 0 || $urandom_range(99) < fresh_pct)
         id = $urandom_range(1) ? FRAME_ID_W'($urandom_range(2047)) : FRAME_ID_W'($urandom);
      else
         id = known_ids[$urandom_range(known_ids.size() - 1)];
      len = ($urandom_range(9) == 0) ? FRAME_LEN_W'($urandom) : FRAME_LEN_W'($urandom_range(8));
      // mostly short steps, now and then a jump anywhere in the tick range
      if ($urandom_range(19) == 0) tick = $urandom();
      else tick = tick + TIME_W'($urandom_range(250));
      send_frame(id, len, {$urandom(), $urandom()}, tick);
   endtask

   // wait until every frame has its result and the block has gone quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic mode, input int entry);
      settle();
      write_reg(REG_FOCUS_MODE, CSR_DATA_W'(mode));
      write_reg(REG_FOCUSED_ENTRY, CSR_DATA_W'(entry));
      focus_on = mode;
      focus_target = entry;
   endtask

   // focus rounds: first entry, last filled, first unfilled, top index, random filled
   task automatic focus_rounds(input int rounds, input int per_round);
      int target;
      for (int r = 0; r < rounds; r++) begin
         case (r % 5)
            0:       target = 0;
            1:       target = known_ids.size() - 1;
            2:       target = known_ids.size();
            3:       target = 127;
            default: target = $urandom_range(known_ids.size() - 1);
         endcase
         configure(1'b1, target);
         repeat (per_round) send_random(15);
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.frame_id      <= '0;
      req_bus.frame_length  <= '0;
      req_bus.frame_payload <= '0;
      req_bus.now_ms        <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.index         <= '0;
      csr_bus.data          <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first frame lands in focus mode on an empty table, then focus hit and miss
      configure(1'b1, 0);
      send_frame(29'h0, 4'd0, 64'h0, 32'h0);
      send_frame(29'h0, 4'd8, '1, 32'hFFFF_FFFF);
      send_frame(29'h1FFF_FFFF, 4'hF, 64'h5555_5555_5555_5555, 32'd10);
      // focused entry never filled: frame ignored
      configure(1'b1, 127);
      send_frame(29'h0, 4'd3, 64'hAAAA_AAAA_AAAA_AAAA, 32'd20);

      // table mode: extreme identifiers, wrapping intervals, zero interval
      configure(1'b0, 127);
      send_frame(29'h0, 4'd1, 64'h0000_0000_0000_00FF, 32'd30);
      send_frame(29'h1FFF_FFFF, 4'd8, '1, 32'hFFFF_FFF0);
      send_frame(29'h7FF, 4'd2, 64'h0123_4567_89AB_CDEF, 32'h8000_0000);
      send_frame(29'h1FFF_FFFF, 4'd0, '0, 32'd5);
      send_frame(29'h1555_5555, 4'd7, 64'h5555_5555_5555_5555, 32'h5555_5555);
      send_frame(29'h0AAA_AAAA, 4'hF, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
      send_frame(29'h7FF, 4'd8, 64'hFEDC_BA98_7654_3210, 32'h8000_0000);

      // table mode, no idling, moderate learning
      repeat (130) send_random(30);

      // focus rounds with an idle sender
      send_idle_pct = 66;
      focus_rounds(5, 26);

      // table mode with a stalling receiver, learning until the table is full
      send_idle_pct = 0;
      recv_stall_pct = 66;
      configure(1'b0, $urandom_range(127));
      repeat (150) send_random(60);

      // both sides idling: focus rounds on a full table, then table mode again
      send_idle_pct = 36;
      recv_stall_pct = 36;
      focus_rounds(5, 24);
      configure(1'b0, 0);
      repeat (20) send_random(40);

      settle();
      $display("%0d frames: %0d entries created, %0d refreshed, %0d dropped when full",
               frames_sent, new_seen, refresh_seen, dropped_seen);
      $display("table and focus modes, focused entry 0 to 127, four pacing mixes");
      if (fail_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
